### src/json_string_unescape_utf8_top_defines.svh
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`endif

### src/jsu_pkg.sv
package jsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CP_W = 21;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK          = 2'd0;
  localparam status_t STATUS_BAD_ESC     = 2'd1;
  localparam status_t STATUS_BAD_UNICODE = 2'd2;

  // one run of utf-8 bytes (len 1 also carries a raw byte in cp[7:0])
  typedef struct packed {
    logic            en;
    logic [2:0]      len;
    logic [CP_W-1:0] cp;
  } seg_t;

  // everything one input item produces
  typedef struct packed {
    seg_t    seg_a;
    seg_t    seg_b;
    logic    stat_en;
    status_t stat_code;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    status_t    status;
    logic       run_last;
    logic       string_done;
  } result_t;

endpackage

### src/jsu_front.sv
module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_last_byte,
  input  logic           q_full,
  output logic           q_push,
  output jsu_pkg::cmd_t  q_cmd
);

  typedef enum logic [2:0] {
    M_NORMAL   = 3'd0,
    M_ESC      = 3'd1,
    M_HEX      = 3'd2,
    M_PEND     = 3'd3,
    M_PEND_ESC = 3'd4,
    M_PEND_HEX = 3'd5,
    M_ERR      = 3'd6
  } mode_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       to_hex;
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b0;
    h.val = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      h.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

  function automatic esc_t plain_esc(input logic [7:0] c);
    esc_t e;
    e.to_hex = 1'b0;
    e.ok = 1'b1;
    e.ch = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: e.ch = c;
      CH_B: e.ch = 8'h08;
      CH_F: e.ch = 8'h0C;
      CH_N: e.ch = 8'h0A;
      CH_R: e.ch = 8'h0D;
      CH_T: e.ch = 8'h09;
      CH_U: begin
        e.to_hex = 1'b1;
        e.ok = 1'b0;
      end
      default: e.ok = 1'b0;
    endcase
    return e;
  endfunction

  function automatic jsu_pkg::seg_t raw_seg(input logic [7:0] c);
    jsu_pkg::seg_t s;
    s.en = 1'b1;
    s.len = 3'd1;
    s.cp = jsu_pkg::CP_W'(c);
    return s;
  endfunction

  function automatic jsu_pkg::seg_t high_seg(input logic [9:0] hh);
    jsu_pkg::seg_t s;
    s.en = 1'b1;
    s.len = 3'd3;
    s.cp = jsu_pkg::CP_W'({HIGH_TAG, hh});
    return s;
  endfunction

  function automatic jsu_pkg::seg_t code_seg(input logic [15:0] v);
    jsu_pkg::seg_t s;
    s.en = 1'b1;
    s.cp = jsu_pkg::CP_W'(v);
    if (v < 16'h0080) begin
      s.len = 3'd1;
    end else if (v < 16'h0800) begin
      s.len = 3'd2;
    end else begin
      s.len = 3'd3;
    end
    return s;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [15:0]            hex_value_r, hex_value_nxt;
  logic [1:0]             hex_count_r, hex_count_nxt;
  logic [9:0]             high_half_r, high_half_nxt;
  jsu_pkg::status_t       error_code_r, error_code_nxt;

  hex_t                   hex;
  esc_t                   esc;
  logic [15:0]            hv_shift;
  logic                   do_esc;
  logic                   accept;
  jsu_pkg::seg_t          seg_a, seg_b;
  logic                   stat_en;
  jsu_pkg::status_t       stat_code;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    mode_nxt       = mode_r;
    hex_value_nxt  = hex_value_r;
    hex_count_nxt  = hex_count_r;
    high_half_nxt  = high_half_r;
    error_code_nxt = error_code_r;
    seg_a          = '0;
    seg_b          = '0;
    stat_en        = 1'b0;
    stat_code      = jsu_pkg::STATUS_OK;
    do_esc         = 1'b0;
    hex            = hex_digit(in_byte);
    esc            = plain_esc(in_byte);
    hv_shift       = {hex_value_r[11:0], hex.val};

    case (mode_r)
      M_NORMAL: begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          seg_b = raw_seg(in_byte);
        end
      end
      M_ESC: do_esc = 1'b1;
      M_PEND_ESC: begin
        if (in_byte == CH_U) begin
          mode_nxt = M_PEND_HEX;
          hex_count_nxt = 2'd0;
          hex_value_nxt = '0;
        end else begin
          seg_a = high_seg(high_half_r);
          do_esc = 1'b1;
        end
      end
      M_HEX, M_PEND_HEX: begin
        if (!hex.ok) begin
          if (mode_r == M_PEND_HEX) seg_a = high_seg(high_half_r);
          stat_en = 1'b1;
          stat_code = jsu_pkg::STATUS_BAD_UNICODE;
          error_code_nxt = jsu_pkg::STATUS_BAD_UNICODE;
          mode_nxt = M_ERR;
        end else begin
          hex_value_nxt = hv_shift;
          if (hex_count_r != 2'd3) begin
            hex_count_nxt = hex_count_r + 2'd1;
          end else begin
            hex_count_nxt = 2'd0;
            if (mode_r == M_PEND_HEX && hv_shift[15:10] == LOW_TAG) begin
              // surrogate pair becomes one 4-byte sequence
              mode_nxt = M_NORMAL;
              seg_b.en = 1'b1;
              seg_b.len = 3'd4;
              seg_b.cp = jsu_pkg::CP_W'(21'h10000) +
                         jsu_pkg::CP_W'({high_half_r, hv_shift[9:0]});
            end else begin
              if (mode_r == M_PEND_HEX) seg_a = high_seg(high_half_r);
              if (hv_shift[15:10] == HIGH_TAG) begin
                high_half_nxt = hv_shift[9:0];
                mode_nxt = M_PEND;
              end else begin
                mode_nxt = M_NORMAL;
                seg_b = code_seg(hv_shift);
              end
            end
          end
        end
      end
      M_PEND: begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = M_PEND_ESC;
        end else begin
          seg_a = high_seg(high_half_r);
          mode_nxt = M_NORMAL;
          seg_b = raw_seg(in_byte);
        end
      end
      default: mode_nxt = M_ERR;
    endcase

    if (do_esc) begin
      mode_nxt = M_NORMAL;
      if (esc.to_hex) begin
        mode_nxt = M_HEX;
        hex_count_nxt = 2'd0;
        hex_value_nxt = '0;
      end else if (esc.ok) begin
        seg_b = raw_seg(esc.ch);
      end else begin
        stat_en = 1'b1;
        stat_code = jsu_pkg::STATUS_BAD_ESC;
        error_code_nxt = jsu_pkg::STATUS_BAD_ESC;
        mode_nxt = M_ERR;
      end
    end

    // close out whatever is still open at the end of the string
    if (in_last_byte) begin
      case (mode_nxt)
        M_ESC: begin
          stat_en = 1'b1;
          stat_code = jsu_pkg::STATUS_BAD_ESC;
        end
        M_HEX: begin
          stat_en = 1'b1;
          stat_code = jsu_pkg::STATUS_BAD_UNICODE;
        end
        M_PEND: seg_b = high_seg(high_half_nxt);
        M_PEND_ESC: begin
          seg_b = high_seg(high_half_nxt);
          stat_en = 1'b1;
          stat_code = jsu_pkg::STATUS_BAD_ESC;
        end
        M_PEND_HEX: begin
          seg_b = high_seg(high_half_nxt);
          stat_en = 1'b1;
          stat_code = jsu_pkg::STATUS_BAD_UNICODE;
        end
        default: ;
      endcase
      if (!seg_a.en && !seg_b.en && !stat_en) begin
        stat_en = 1'b1;
        stat_code = error_code_nxt;
      end
    end
  end

  assign q_cmd.seg_a     = seg_a;
  assign q_cmd.seg_b     = seg_b;
  assign q_cmd.stat_en   = stat_en;
  assign q_cmd.stat_code = stat_code;
  assign q_cmd.last      = in_last_byte;
  assign q_push          = accept && (seg_a.en || seg_b.en || stat_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_NORMAL;
      hex_value_r  <= '0;
      hex_count_r  <= '0;
      high_half_r  <= '0;
      error_code_r <= jsu_pkg::STATUS_OK;
    end else if (accept) begin
      if (in_last_byte) begin
        mode_r       <= M_NORMAL;
        hex_value_r  <= '0;
        hex_count_r  <= '0;
        high_half_r  <= '0;
        error_code_r <= jsu_pkg::STATUS_OK;
      end else begin
        mode_r       <= mode_nxt;
        hex_value_r  <= hex_value_nxt;
        hex_count_r  <= hex_count_nxt;
        high_half_r  <= high_half_nxt;
        error_code_r <= error_code_nxt;
      end
    end
  end

endmodule

### src/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::cmd_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t     entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### src/jsu_back.sv
module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::cmd_t    head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output jsu_pkg::result_t out_res
);

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_S = 2'd2
  } sel_t;

  sel_t              sel_r, cur;
  logic [1:0]        pos_r;
  logic              out_valid_r;
  jsu_pkg::result_t  out_res_r, res;

  jsu_pkg::seg_t     seg;
  logic [2:0]        len;
  logic [1:0]        k;
  logic              seg_end, later, is_final, load, emit;

  assign load = !out_valid_r || !out_stall;
  assign emit = load && !empty;

  always_comb begin
    // first enabled segment at or after the current one
    if (sel_r == SEL_A && head.seg_a.en) begin
      cur = SEL_A;
    end else if (sel_r != SEL_S && head.seg_b.en) begin
      cur = SEL_B;
    end else begin
      cur = SEL_S;
    end
    seg      = (cur == SEL_A) ? head.seg_a : head.seg_b;
    len      = (cur == SEL_S) ? 3'd1 : seg.len;
    seg_end  = (3'(pos_r) + 3'd1) == len;
    case (cur)
      SEL_A:   later = head.seg_b.en || head.stat_en;
      SEL_B:   later = head.stat_en;
      default: later = 1'b0;
    endcase
    is_final = seg_end && !later;
    k        = 2'(len - 3'd1 - 3'(pos_r));

    res.data       = 8'h00;
    res.data_valid = 1'b1;
    res.status     = jsu_pkg::STATUS_OK;
    if (cur == SEL_S) begin
      res.data_valid = 1'b0;
      res.status     = head.stat_code;
    end else if (len == 3'd1) begin
      res.data = seg.cp[7:0];
    end else if (pos_r == 2'd0) begin
      case (len)
        3'd2:    res.data = {3'b110, seg.cp[10:6]};
        3'd3:    res.data = {4'b1110, seg.cp[15:12]};
        default: res.data = {5'b11110, seg.cp[20:18]};
      endcase
    end else begin
      case (k)
        2'd1:    res.data = {2'b10, seg.cp[11:6]};
        2'd2:    res.data = {2'b10, seg.cp[17:12]};
        default: res.data = {2'b10, seg.cp[5:0]};
      endcase
    end
    res.run_last    = is_final;
    res.string_done = is_final && head.last;
  end

  assign pop       = emit && is_final;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= SEL_A;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        if (is_final) begin
          sel_r <= SEL_A;
          pos_r <= '0;
        end else if (seg_end) begin
          sel_r <= (cur == SEL_A) ? SEL_B : SEL_S;
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + 2'd1;
        end
      end else if (load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res_r <= res;
  end

endmodule

### src/json_string_unescape_utf8_top.sv
// json string body unescaper, utf-8 out
// input channel: in_valid/in_stall with in_byte and in_last_byte, one body
// byte per item, quotes excluded, in_last_byte high on the final byte
// result channel: out_valid/out_stall with out_byte, out_byte_valid,
// out_status, out_run_last and out_string_done; several results may follow
// one input item, out_run_last marks the final one, out_string_done the
// final one of the string
// path: an accepted item is written into the command queue, and its first
// result is then loaded from the queue head into the output register, where
// the receiver can take it
// throughput: one input item per cycle while each gives at most one result and
// out_stall is low; the output sequencer emits one result per cycle unless
// stalled, so an item with several results holds it until all are out, and
// the command queue (QUEUE_DEPTH entries) absorbs bursts before in_stall rises
// reset clears the decoder, the queue and the output valid flag; after the
// final byte of a string the decoder is back in its reset state
// when the receiver stalls, the output register holds its result, the queue
// fills, and then in_stall rises until space frees up
module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic [1:0]       out_status,
  output logic             out_run_last,
  output logic             out_string_done
);

  jsu_pkg::cmd_t     push_cmd, head_cmd;
  logic              q_push, q_full, q_pop, q_empty;
  jsu_pkg::result_t  res;

  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_cmd),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_byte        = res.data;
  assign out_byte_valid  = res.data_valid;
  assign out_status      = res.status;
  assign out_run_last    = res.run_last;
  assign out_string_done = res.string_done;

endmodule

### src/jsu_checker.sv
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic [1:0] out_status,
  input logic       out_run_last,
  input logic       out_string_done
);

  // a stalled result holds
  `JSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_byte_valid) && $stable(out_status) && $stable(out_string_done))

  // data results never carry an error
  `JSU_ASSERT_NOW(a_data_ok, clk, rst_n, out_valid && out_byte_valid,
    out_status == jsu_pkg::STATUS_OK)

  // an error closes the results of its item
  `JSU_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && out_status != jsu_pkg::STATUS_OK,
    out_run_last && !out_byte_valid && out_byte == 8'h00)

  // end of string is always the end of an item
  `JSU_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && out_string_done, out_run_last)

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);
